// File: sv/mlpq_pkg.sv
// Package for the multi-level priority queue.
// Holds the opcode and status codes and the control structs shared by the pointer file and the top level.
package mlpq_pkg;

  // Operation requested by an input transfer.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Completion status reported with every result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Update request to the per-level pointer file.
  typedef struct packed {
    logic push;
    logic pop;
  } ptr_cmd_t;

  // Occupancy of the currently selected level.
  typedef struct packed {
    logic empty;
    logic full;
  } ptr_stat_t;

endpackage

// File: sv/mlpq_store.sv
// Entry store of the multi-level priority queue: one write port and one
// registered read port. No dependencies.
module mlpq_store #(
  parameter int ENTRIES = 64,
  parameter int DATA_W  = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem_q [ENTRIES];
  logic [DATA_W-1:0] rdata_q;

  // Synchronous write and registered read; contents are undefined until written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mlpq_ptrs.sv
// Per-level ring pointers and fill counts of the multi-level priority queue.
// Depends on mlpq_pkg for the command and status structs.
module mlpq_ptrs #(
  parameter int LEVELS = 8,
  parameter int DEPTH  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [$clog2(LEVELS)-1:0] lvl_i,
  input  mlpq_pkg::ptr_cmd_t        cmd_i,
  output mlpq_pkg::ptr_stat_t       stat_o,
  output logic [$clog2(DEPTH)-1:0]  head_o,
  output logic [$clog2(DEPTH)-1:0]  tail_o
);

  import mlpq_pkg::*;

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [SW-1:0] head_q  [LEVELS];
  logic [SW-1:0] tail_q  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];

  logic [SW-1:0] head_sel;
  logic [SW-1:0] tail_sel;
  logic [CW-1:0] count_sel;

  // Advance a slot index with wrap from the last slot back to zero.
  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SW'(1);
    end
    return r;
  endfunction

  // Read the selected level.
  always_comb begin
    head_sel     = head_q[lvl_i];
    tail_sel     = tail_q[lvl_i];
    count_sel    = count_q[lvl_i];
    stat_o.empty = (count_sel == '0);
    stat_o.full  = (count_sel == CW'(DEPTH));
  end

  assign head_o = head_sel;
  assign tail_o = tail_sel;

  // Update the selected level on a push or a pop; reset empties every ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cmd_i.push) begin
        tail_q[lvl_i]  <= next_slot(tail_sel);
        count_q[lvl_i] <= count_sel + CW'(1);
      end
      if (cmd_i.pop) begin
        head_q[lvl_i]  <= next_slot(head_sel);
        count_q[lvl_i] <= count_sel - CW'(1);
      end
    end
  end

endmodule

// File: sv/multi_level_priority_queue.sv
// Top level of the multi-level priority queue: sequencer, level scan and result register.
// Depends on mlpq_pkg, mlpq_ptrs and mlpq_store.
//
// Usage: a command is transferred at a rising edge with start high and busy low.
// opcode_i selects insert (item_in_i goes to the tail of ring priority_req_i) or
// remove (head of the lowest-numbered non-empty ring). Every command gives exactly
// one result: done_o is high for one cycle with item_out_o, from_level_o and status_o.
// The receiver cannot stall the block; a result must be taken in its cycle.
//
// Timing: an insert holds busy while in the insert state, and its result is registered
// as it leaves that state; no new command is taken while busy. A remove scans the
// levels one per cycle from level 0 up, with a single compare on the selected fill count;
// at the first non-empty level it pops that ring and starts the registered store read,
// and the result register takes the entry in the read state.
// A remove on an empty queue scans all LEVELS levels and reports underflow.
// A new command may be transferred in the cycle that the previous result is shown.
//
// Reset: all rings are empty and no result is pending; the entry store is not
// cleared, since an entry is only read after it was written.
module multi_level_priority_queue #(
  parameter int LEVELS = 8,
  parameter int DEPTH  = 8,
  parameter int DATA_W = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] item_in_i,
  input  logic [2:0]  priority_req_i,
  output logic        done_o,
  output logic [31:0] item_out_o,
  output logic [2:0]  from_level_o,
  output logic [1:0]  status_o
);

  import mlpq_pkg::*;

  localparam int LW      = $clog2(LEVELS);
  localparam int SW      = $clog2(DEPTH);
  localparam int ENTRIES = LEVELS * DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SCAN = 4'b0100,
    S_READ = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic              bad_q, bad_d;
  logic [DATA_W-1:0] item_q, item_d;
  logic              done_q, done_d;
  logic [31:0]       res_item_q, res_item_d;
  logic [2:0]        res_lvl_q, res_lvl_d;
  status_e           res_st_q, res_st_d;

  ptr_cmd_t          cmd;
  ptr_stat_t         stat;
  logic [SW-1:0]     head;
  logic [SW-1:0]     tail;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic              accept;
  logic              pri_ok;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign pri_ok = (32'(priority_req_i) < 32'(LEVELS));

  // Ring slot to flat store address.
  assign waddr = AW'(32'(lvl_q) * DEPTH + 32'(tail));
  assign raddr = AW'(32'(lvl_q) * DEPTH + 32'(head));

  // Sequencer: capture the command, then insert or scan for the first non-empty level.
  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    bad_d      = bad_q;
    item_d     = item_q;
    done_d     = 1'b0;
    res_item_d = res_item_q;
    res_lvl_d  = res_lvl_q;
    res_st_d   = res_st_q;
    cmd        = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = DATA_W'(item_in_i);
          if (opcode_i == OP_REMOVE) begin
            lvl_d   = '0;
            bad_d   = 1'b0;
            state_d = S_SCAN;
          end else begin
            lvl_d   = pri_ok ? LW'(priority_req_i) : '0;
            bad_d   = !pri_ok;
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        res_item_d = '0;
        res_lvl_d  = '0;
        done_d     = 1'b1;
        state_d    = S_IDLE;
        if (bad_q || stat.full) begin
          res_st_d = ST_OVERFLOW;
        end else begin
          res_st_d = ST_OK;
          cmd.push = 1'b1;
          mem_we   = 1'b1;
        end
      end
      S_SCAN: begin
        if (!stat.empty) begin
          cmd.pop = 1'b1;
          mem_re  = 1'b1;
          state_d = S_READ;
        end else if (lvl_q == LW'(LEVELS - 1)) begin
          res_item_d = '0;
          res_lvl_d  = '0;
          res_st_d   = ST_UNDERFLOW;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      S_READ: begin
        res_item_d = 32'(rdata);
        res_lvl_d  = 3'(lvl_q);
        res_st_d   = ST_OK;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    bad_q      <= bad_d;
    item_q     <= item_d;
    res_item_q <= res_item_d;
    res_lvl_q  <= res_lvl_d;
    res_st_q   <= res_st_d;
  end

  assign done_o       = done_q;
  assign item_out_o   = res_item_q;
  assign from_level_o = res_lvl_q;
  assign status_o     = res_st_q;

  mlpq_ptrs #(
    .LEVELS(LEVELS),
    .DEPTH (DEPTH)
  ) u_ptrs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .lvl_i (lvl_q),
    .cmd_i (cmd),
    .stat_o(stat),
    .head_o(head),
    .tail_o(tail)
  );

  mlpq_store #(
    .ENTRIES(ENTRIES),
    .DATA_W (DATA_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(item_q),
    .re_i   (mem_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule
